>>> hw/rtl/aes128_block_encrypt_unit_assert.svh
// Assertion macros used by the port checker.
`ifndef AES128_BLOCK_ENCRYPT_UNIT_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// S-box, round constants, round helper functions and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int BLOCK_W    = 128;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_ECB = 2'd0;
    localparam mode_t MODE_CBC = 2'd1;
    localparam mode_t MODE_CTR = 2'd2;

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_KEY_HIGH = 2'd0;
    localparam cfg_idx_t CFG_KEY_LOW  = 2'd1;
    localparam cfg_idx_t CFG_MODE     = 2'd2;

    localparam logic [7:0] POLY_REDUCE = 8'h1b;
    localparam logic [7:0] MSB_MASK    = 8'h80;

    // Per-stage sideband that travels with a block through the rounds.
    typedef struct packed {
        logic         ctr;
        logic [127:0] text;
    } side_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        unique case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Round constant for rounds 1 to 10.
    function automatic logic [7:0] rcon(input logic [3:0] rnd);
        logic [7:0] r;
        unique case (rnd)
            4'd1: r = 8'h01;  4'd2: r = 8'h02;  4'd3: r = 8'h04;
            4'd4: r = 8'h08;  4'd5: r = 8'h10;  4'd6: r = 8'h20;
            4'd7: r = 8'h40;  4'd8: r = 8'h80;  4'd9: r = 8'h1b;
            4'd10: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (((a & MSB_MASK) != 8'h00) ? POLY_REDUCE : 8'h00);
    endfunction

    // Byte i of the block sits at bits 127-8i down to 120-8i.
    function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
        return s[127 - 8 * i -: 8];
    endfunction

    // Next round key from the previous one.
    function automatic logic [127:0] next_key(input logic [127:0] k,
                                              input logic [3:0] rnd);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t = {sbox(w3[23:16]) ^ rcon(rnd), sbox(w3[15:8]), sbox(w3[7:0]),
             sbox(w3[31:24])};
        w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // SubBytes, ShiftRows and, unless last, MixColumns.
    function automatic logic [127:0] round_core(input logic [127:0] s,
                                                input logic last);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, all;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[127 - 8 * (r + 4 * c) -: 8] = sbox(get_byte(s, r + 4 * ((c + r) % 4)));
        if (!last)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = get_byte(t, 4 * c);     a1 = get_byte(t, 4 * c + 1);
                a2 = get_byte(t, 4 * c + 2); a3 = get_byte(t, 4 * c + 3);
                all = a0 ^ a1 ^ a2 ^ a3;
                t[127 - 32 * c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1),
                                         a1 ^ all ^ xtime(a1 ^ a2),
                                         a2 ^ all ^ xtime(a2 ^ a3),
                                         a3 ^ all ^ xtime(a3 ^ a0)};
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/aes_round_cell.sv
// ----------------------------------------------------------------------------
// AES round cell
// One round of the chain: holds a block, its round key and sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round_cell #(
    parameter logic [3:0] ROUND = 4'd1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire logic                valid_in,
    input  wire logic [127:0]        state_in,
    input  wire logic [127:0]        key_in,
    input  wire aes_pkg::side_t      side_in,
    output logic                     valid_out,
    output logic [127:0]             state_out,
    output logic [127:0]             key_out,
    output aes_pkg::side_t           side_out
);
    import aes_pkg::*;

    logic           valid_reg;
    logic [127:0]   state_reg, state_next;
    logic [127:0]   key_reg, key_next;
    side_t          side_reg;

    always_comb
    begin
        key_next   = next_key(key_in, ROUND);
        state_next = round_core(state_in, ROUND == 4'(NUM_ROUNDS)) ^ key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
            side_reg  <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;
    assign key_out   = key_reg;
    assign side_out  = side_reg;

endmodule

`default_nettype wire

>>> hw/rtl/aes128_block_encrypt_unit.sv
// ----------------------------------------------------------------------------
// AES-128 block encrypt unit
// Pipelined AES-128 with ECB, single-block CBC and counter modes.
// ----------------------------------------------------------------------------
// Channel   Signals                                   Direction
// cfg       cfg_valid/ready, cfg_index, cfg_data      write
// in        in_valid/ready, text_*, nonce_*           input
// out       out_valid/ready, cipher_*                 output
//
// One block per cycle is accepted unless the chain stalls; a block passes
// the input stage and then ten round cells, each round key expanded alongside it.
// Reset clears all valid flags and the configuration registers to zero.
// The whole chain stalls only when the output stage holds a result that is
// not taken, and no new block enters while that result waits.
`default_nettype none

module aes128_block_encrypt_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [63:0]  cfg_data,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [63:0]  text_high,
    input  wire logic [63:0]  text_low,
    input  wire logic [63:0]  nonce_high,
    input  wire logic [63:0]  nonce_low,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [63:0]       cipher_high,
    output logic [63:0]       cipher_low
);
    import aes_pkg::*;

    logic [63:0]  key_high_reg, key_low_reg;
    mode_t        mode_reg;
    logic         advance;

    logic         v [0:NUM_ROUNDS];
    logic [127:0] st [0:NUM_ROUNDS];
    logic [127:0] ky [0:NUM_ROUNDS];
    side_t        sd [0:NUM_ROUNDS];

    logic         v0_reg;
    logic [127:0] st0_reg, ky0_reg;
    side_t        sd0_reg;
    logic [127:0] pre;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            mode_reg     <= MODE_ECB;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_MODE:     mode_reg     <= cfg_data[1:0];
                default:      ;
            endcase
        end
    end

    // The last cell is the output register; the chain moves unless it is held.
    assign advance  = !v[NUM_ROUNDS] || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        unique case (mode_reg)
            MODE_ECB: pre = {text_high, text_low};
            MODE_CBC: pre = {text_high, text_low} ^ {nonce_high, nonce_low};
            default:  pre = {nonce_high, nonce_low};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (advance)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st0_reg      <= pre ^ {key_high_reg, key_low_reg};
            ky0_reg      <= {key_high_reg, key_low_reg};
            sd0_reg.ctr  <= mode_reg[1];
            sd0_reg.text <= {text_high, text_low};
        end
    end

    assign v[0]  = v0_reg;
    assign st[0] = st0_reg;
    assign ky[0] = ky0_reg;
    assign sd[0] = sd0_reg;

    for (genvar g = 1; g <= NUM_ROUNDS; g++)
    begin : g_round
        aes_round_cell #(.ROUND(4'(g))) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (v[g - 1]),
            .state_in  (st[g - 1]),
            .key_in    (ky[g - 1]),
            .side_in   (sd[g - 1]),
            .valid_out (v[g]),
            .state_out (st[g]),
            .key_out   (ky[g]),
            .side_out  (sd[g])
        );
    end

    assign out_valid = v[NUM_ROUNDS];
    assign {cipher_high, cipher_low} = sd[NUM_ROUNDS].ctr
        ? (st[NUM_ROUNDS] ^ sd[NUM_ROUNDS].text) : st[NUM_ROUNDS];

endmodule

`default_nettype wire

>>> hw/rtl/aes_port_checker.sv
// ----------------------------------------------------------------------------
// AES port checker
// Port-level checks on the encrypt unit, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "aes128_block_encrypt_unit_assert.svh"

module aes_port_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         in_ready,
    input wire logic         out_valid,
    input wire logic         out_ready,
    input wire logic [63:0]  cipher_high,
    input wire logic [63:0]  cipher_low
);
    `AES_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `AES_ASSERT_NEXT(a_data_hold, clk, rst_n, out_valid && !out_ready, $stable(cipher_high) && $stable(cipher_low))
    `AES_ASSERT_IMP(a_ready_free, clk, rst_n, !out_valid, in_ready)
    `AES_ASSERT_IMP(a_ready_take, clk, rst_n, out_ready, in_ready)

endmodule

bind aes128_block_encrypt_unit aes_port_checker u_aes_port_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cipher_high (cipher_high),
    .cipher_low  (cipher_low)
);

`default_nettype wire
